// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers, clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define SPQ_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// Antecedent implies consequent at the next edge.
`define SPQ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
package spq_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_MODIFY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_REMOVE,
		S_PLACE,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_MARK_ALL,
		OP_MARK_MATCH,
		OP_REMOVE,
		OP_PLACE
	} cell_op_t;

	typedef struct packed {
		logic        vld;
		logic [31:0] value;
		logic [31:0] prio;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] key;
		entry_t      ins;
	} cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t    prev_ent,
	input  logic               prev_goes,
	input  logic               prev_after,
	input  logic [31:0]        prev_stamp,
	input  spq_pkg::entry_t    next_ent,
	output spq_pkg::entry_t    ent,
	output logic               goes,
	output logic               after,
	output logic [31:0]        found_stamp
);
	import spq_pkg::*;

	entry_t ent_q;
	entry_t ent_d;
	logic   shift_q;
	logic   shift_d;
	logic   stays;
	logic   match;
	logic   first;

	// held entry stays ahead of the new one unless lower priority, or equal and younger
	always_comb begin
		stays = ($signed(ent_q.prio) > $signed(ctrl.ins.prio)) ||
			((ent_q.prio == ctrl.ins.prio) && (ent_q.stamp <= ctrl.ins.stamp));
		goes = !ent_q.vld || !stays;
		match = ent_q.vld && (ent_q.value == ctrl.key);
		after = prev_after | match;
		first = match & !prev_after;
		found_stamp = prev_stamp | (first ? ent_q.stamp : 32'd0);
	end

	always_comb begin
		ent_d = ent_q;
		shift_d = shift_q;
		case (ctrl.op)
			OP_MARK_ALL: shift_d = 1'b1;
			OP_MARK_MATCH: shift_d = after;
			OP_REMOVE: begin
				if (shift_q) ent_d = next_ent;
			end
			OP_PLACE: begin
				if (prev_goes) ent_d = prev_ent;
				else if (goes) ent_d = ctrl.ins;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			shift_q <= 1'b0;
		end else begin
			ent_q <= ent_d;
			shift_q <= shift_d;
		end
	end

	assign ent = ent_q;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Bounded priority queue kept sorted in a row of DEPTH cells, highest priority at the head,
// equal priorities oldest first. One command is taken at a time: insert passes through a place
// step and extract through a remove step (both go straight to the result on a full or an empty
// queue), peek goes straight to the result, and modify searches, removes and re-places, or only
// searches when the value is absent, the cell row doing one parallel compare-and-shift per step;
// the input is stalled until the result sits in the output register. Insert on a full queue
// reports full, modify of an absent value reports not found.
`include "assert_macros.svh"

module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic signed [31:0] item_value,
	input  logic signed [31:0] item_priority,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic signed [31:0] out_value,
	output logic signed [31:0] out_priority,
	output logic [4:0]  fill_count
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t      state_q;
	state_t      state_d;
	logic [CW-1:0] count_q;
	logic [31:0] stamp_ctr_q;
	cmd_t        cmd_q;
	logic [31:0] val_q;
	logic [31:0] pri_q;
	logic [31:0] stamp_q;
	status_t     status_q;
	logic [31:0] res_val_q;
	logic [31:0] res_pri_q;
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_val_q;
	logic [31:0] out_pri_q;
	logic [4:0]  out_fill_q;

	cell_ctrl_t  ctrl;
	entry_t      ents [DEPTH];
	logic        goes [DEPTH];
	logic        after [DEPTH];
	logic [31:0] fstamp [DEPTH];
	logic [DEPTH-1:0] vld_vec;

	logic        accept;
	logic        empty;
	logic        full;
	logic        found;
	logic        deliver;
	cmd_t        in_cmd;

	assign in_cmd = cmd_t'(command);
	assign accept = in_valid && !in_stall;
	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign found = after[DEPTH-1];
	assign deliver = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			entry_t      p_ent;
			entry_t      n_ent;
			logic        p_goes;
			logic        p_after;
			logic [31:0] p_stamp;
			if (gi == 0) begin : g_first
				assign p_ent = '0;
				assign p_goes = 1'b0;
				assign p_after = 1'b0;
				assign p_stamp = 32'd0;
			end else begin : g_mid
				assign p_ent = ents[gi-1];
				assign p_goes = goes[gi-1];
				assign p_after = after[gi-1];
				assign p_stamp = fstamp[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign n_ent = '0;
			end else begin : g_next
				assign n_ent = ents[gi+1];
			end
			spq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.prev_ent    (p_ent),
				.prev_goes   (p_goes),
				.prev_after  (p_after),
				.prev_stamp  (p_stamp),
				.next_ent    (n_ent),
				.ent         (ents[gi]),
				.goes        (goes[gi]),
				.after       (after[gi]),
				.found_stamp (fstamp[gi])
			);
			assign vld_vec[gi] = ents[gi].vld;
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_cmd)
						CMD_INSERT: state_d = full ? S_DONE : S_PLACE;
						CMD_EXTRACT: state_d = empty ? S_DONE : S_REMOVE;
						CMD_PEEK: state_d = S_DONE;
						CMD_MODIFY: state_d = S_FIND;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FIND: state_d = found ? S_REMOVE : S_DONE;
			S_REMOVE: state_d = (cmd_q == CMD_MODIFY) ? S_PLACE : S_DONE;
			S_PLACE: state_d = S_DONE;
			S_DONE: state_d = deliver ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != S_IDLE);
		ctrl.op = OP_HOLD;
		ctrl.key = val_q;
		ctrl.ins = '{vld: 1'b1, value: val_q, prio: pri_q, stamp: stamp_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept && (in_cmd == CMD_EXTRACT)) ctrl.op = OP_MARK_ALL;
			end
			S_FIND: ctrl.op = OP_MARK_MATCH;
			S_REMOVE: ctrl.op = OP_REMOVE;
			S_PLACE: ctrl.op = OP_PLACE;
			S_DONE: ctrl.op = OP_HOLD;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			stamp_ctr_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (in_cmd == CMD_INSERT) && !full) stamp_ctr_q <= stamp_ctr_q + 32'd1;
			if (state_q == S_REMOVE) count_q <= count_q - CW'(1);
			else if (state_q == S_PLACE) count_q <= count_q + CW'(1);
			if (deliver) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			val_q <= item_value;
			pri_q <= item_priority;
			status_q <= ST_OK;
			res_val_q <= 32'd0;
			res_pri_q <= 32'd0;
			stamp_q <= stamp_ctr_q + 32'd1;
			unique case (in_cmd) inside
				CMD_INSERT: begin
					if (full) status_q <= ST_FULL;
				end
				CMD_EXTRACT, CMD_PEEK: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						res_val_q <= ents[0].value;
						res_pri_q <= ents[0].prio;
					end
				end
				CMD_MODIFY: ;
				default: ;
			endcase
		end
		if (state_q == S_FIND) begin
			if (found) stamp_q <= fstamp[DEPTH-1];
			else status_q <= ST_NOT_FOUND;
		end
		if (deliver) begin
			out_status_q <= status_q;
			out_val_q <= res_val_q;
			out_pri_q <= res_pri_q;
			out_fill_q <= 5'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign out_value = out_val_q;
	assign out_priority = out_pri_q;
	assign fill_count = out_fill_q;

	`SPQ_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH), "entry count above depth")
	`SPQ_ASSERT(a_vld_count, clk, arst_n, $countones(vld_vec) == int'(count_q),
		"valid cells disagree with entry count")
	`SPQ_ASSERT(a_vld_packed, clk, arst_n, (vld_vec & (vld_vec + DEPTH'(1))) == '0,
		"valid cells not packed at the head")
	`SPQ_ASSERT_NEXT(a_full_kept, clk, arst_n,
		deliver && (status_q == ST_FULL), count_q == CW'(DEPTH),
		"full status reported on a queue that is not full")

endmodule
